@@ rtl/core/assert_macros.svh @@
// Assertion macros for the RTL of the run-length encoder.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RLE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/core/rle_pkg.sv @@
// Types, constants and helpers of the RGB565 run-length encoder.
// Depends on nothing; used by the encoder modules and the testbench.
package rle_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned ColorW = 16;
    localparam int unsigned CountW = 16;

    // A run is closed as soon as its count reaches this value.
    localparam logic [CountW-1:0] RunLimit = 16'hFFFF;

    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
        logic             final_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CountW-1:0] run_length;
        logic [ColorW-1:0] run_color;
        logic              image_end;
    } record_t;

    // Records caused by one pixel; first is always meaningful when the bundle is valid.
    typedef struct packed {
        logic    two;
        record_t first;
        record_t second;
    } bundle_t;

    function automatic logic [ColorW-1:0] to_rgb565(input pixel_t px);
        return {px.red[7:3], px.green[7:2], px.blue[7:3]};
    endfunction

endpackage

@@ rtl/core/rle_stream_if.sv @@
// Valid/ready stream interface used for the pixel and record channels.
// Depends on nothing; the payload type is chosen at instantiation.
interface rle_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/core/rgb565_run_length_encoder_unit.sv @@
// RGB565 run-length encoder, top level.
// Depends on rle_pkg, rle_stream_if, rle_run_tracker, rle_record_serializer, assert_macros.svh.
//
// Usage: pixels arrive on the "pixels" stream (RGB888 plus a final_pixel flag) in raster
// order; each transaction is accepted when valid and ready are both high. Each pixel is
// reduced to RGB565 and merged into the pending run. Run records (length, colour,
// image_end) leave on the "records" stream, one record per transaction.
// A pixel produces zero, one or two records: a colour change closes the previous run,
// a run reaching 65535 pixels is closed at once, and the final pixel flushes the pending
// run with image_end set. After the final pixel the run state returns to its reset value,
// so the next pixel starts a new image.
// A record passes through the bundle register and then the output register on its way out.
// Throughput: one pixel per cycle while each pixel closes at most one run and the record
// receiver does not stall; a pixel that yields two records can hold the input back, because
// the output register sends one record per cycle.
// Reset (rst_n low, asynchronous) empties both pipeline registers and clears the pending
// colour and count; no clearing pass is needed.
// When the record receiver stalls, the output register and a second-record slot hold
// their data, and the stall reaches the pixel input once the bundle register is full.
`include "assert_macros.svh"

module rgb565_run_length_encoder_unit (
    input  logic         clk,
    input  logic         rst_n,
    rle_stream_if.sink   pixels,
    rle_stream_if.source records
);

    logic             bundle_valid;
    logic             bundle_ready;
    rle_pkg::bundle_t bundle;

    // Colour compare, count increment and record assembly, registered into a bundle.
    rle_run_tracker u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixels       (pixels),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .bundle_ready (bundle_ready)
    );

    // Splits a bundle into one transaction per record behind the output register.
    rle_record_serializer u_serializer (
        .clk          (clk),
        .rst_n        (rst_n),
        .bundle_valid (bundle_valid),
        .bundle       (bundle),
        .bundle_ready (bundle_ready),
        .records      (records)
    );

    // A record never describes an empty run.
    `RLE_ASSERT_IMPLIES(a_nonempty_run, clk, rst_n, records.valid,
        records.data.run_length != '0)
    // Two records from one pixel: the closed run first, then the flushed final run.
    `RLE_ASSERT_IMPLIES(a_pair_order, clk, rst_n, bundle_valid && bundle.two,
        !bundle.first.image_end && bundle.second.image_end)
    // The two records of a pixel come from a colour change, so their colours differ.
    `RLE_ASSERT_IMPLIES(a_pair_colors, clk, rst_n, bundle_valid && bundle.two,
        bundle.first.run_color != bundle.second.run_color)

endmodule

@@ rtl/core/rle_run_tracker.sv @@
// Run tracking: keeps the pending colour and count and builds the records of each pixel.
// Depends on rle_pkg and rle_stream_if.
module rle_run_tracker (
    input  logic               clk,
    input  logic               rst_n,
    rle_stream_if.sink         pixels,
    output logic               bundle_valid,
    output rle_pkg::bundle_t   bundle,
    input  logic               bundle_ready
);

    logic [rle_pkg::ColorW-1:0] prev_color_reg, prev_color_next;
    logic [rle_pkg::CountW-1:0] count_reg, count_next;
    logic                       bundle_valid_reg;
    rle_pkg::bundle_t           bundle_reg, bundle_next;

    logic [rle_pkg::ColorW-1:0] color;
    logic [rle_pkg::CountW-1:0] base, count_inc;
    logic                       change, hit, last, close_run, has_record, accept;
    rle_pkg::record_t           rec_old, rec_new;

    assign pixels.ready = !bundle_valid_reg || bundle_ready;
    assign accept       = pixels.valid && pixels.ready;

    always_comb
    begin
        color     = rle_pkg::to_rgb565(pixels.data);
        last      = pixels.data.final_pixel;
        change    = (color != prev_color_reg) && (count_reg != '0);
        base      = change ? '0 : count_reg;
        count_inc = base + {{(rle_pkg::CountW-1){1'b0}}, 1'b1};
        hit       = (count_inc == rle_pkg::RunLimit);
        close_run = hit || last;

        rec_old.run_length = count_reg;
        rec_old.run_color  = prev_color_reg;
        rec_old.image_end  = 1'b0;

        rec_new.run_length = count_inc;
        rec_new.run_color  = color;
        rec_new.image_end  = last;

        has_record         = change || close_run;
        bundle_next.two    = change && close_run;
        bundle_next.first  = change ? rec_old : rec_new;
        bundle_next.second = rec_new;

        count_next      = close_run ? '0 : count_inc;
        prev_color_next = last ? '0 : color;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_color_reg   <= '0;
            count_reg        <= '0;
            bundle_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prev_color_reg <= prev_color_next;
                count_reg      <= count_next;
            end
            if (pixels.ready)
            begin
                bundle_valid_reg <= accept && has_record;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && has_record)
        begin
            bundle_reg <= bundle_next;
        end
    end

    assign bundle_valid = bundle_valid_reg;
    assign bundle       = bundle_reg;

endmodule

@@ rtl/core/rle_record_serializer.sv @@
// Output stage: sends the one or two records of a bundle as separate transactions.
// Depends on rle_pkg and rle_stream_if.
module rle_record_serializer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               bundle_valid,
    input  rle_pkg::bundle_t   bundle,
    output logic               bundle_ready,
    rle_stream_if.source       records
);

    logic             out_valid_reg, extra_valid_reg;
    rle_pkg::record_t out_reg, extra_reg;
    logic             advance;

    // The output register moves whenever it is empty or being taken.
    assign advance      = !out_valid_reg || records.ready;
    assign bundle_ready = !extra_valid_reg && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            extra_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (extra_valid_reg)
            begin
                out_valid_reg   <= 1'b1;
                extra_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg   <= bundle_valid;
                extra_valid_reg <= bundle_valid && bundle.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (extra_valid_reg)
            begin
                out_reg <= extra_reg;
            end
            else if (bundle_valid)
            begin
                out_reg   <= bundle.first;
                extra_reg <= bundle.second;
            end
        end
    end

    assign records.valid = out_valid_reg;
    assign records.data  = out_reg;

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for rgb565_run_length_encoder_unit.
// Depends on rle_pkg, rle_stream_if and rgb565_run_length_encoder_unit. It drives pixels,
// predicts the run records in place and checks every record against that prediction.
`timescale 1ns / 1ps

module tb;

    // Far above the slowest correct run: three full-length runs plus the random images.
    localparam int CycleLimit    = 4000000;
    // Records trail their pixel through the bundle and output registers, so a short quiet time covers them.
    localparam int SettleCycles  = 8;
    localparam int ImageItems    = 400;

    logic clk = 1'b0;
    logic rst_n;

    rle_stream_if #(.payload_t(rle_pkg::pixel_t))  pixels_if ();
    rle_stream_if #(.payload_t(rle_pkg::record_t)) records_if ();

    rgb565_run_length_encoder_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels_if),
        .records (records_if)
    );

    // Predicted run state, mirroring the pending colour and count of the encoder.
    logic [rle_pkg::ColorW-1:0] pending_color;
    logic [rle_pkg::CountW-1:0] pending_length;

    // Records that the encoder still owes, oldest first.
    rle_pkg::record_t expected_records[$];

    int error_count;
    int cycle_count;

    // Chance, in percent, that the pixel sender idles or the record receiver stalls
    // in a given cycle. Each test phase sets its own pair.
    int send_idle_pct;
    int stall_pct;

    always #2 clk = ~clk;

    // The receiver decides its ready at each falling edge so that it is stable by the
    // rising edge where the record transaction is sampled.
    always @(negedge clk)
    begin
        records_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic rle_pkg::pixel_t make_pixel(input logic [7:0] red,
                                                   input logic [7:0] green,
                                                   input logic [7:0] blue,
                                                   input logic final_pixel);
        rle_pkg::pixel_t px;
        px.red         = red;
        px.green       = green;
        px.blue        = blue;
        px.final_pixel = final_pixel;
        return px;
    endfunction

    // Folds one accepted pixel into the predicted run state and queues every record
    // that this pixel closes. A pixel can close at most two runs: the previous run on
    // a colour change, and then its own run when it is the final pixel.
    task automatic predict_run_records(input rle_pkg::pixel_t px);
        logic [rle_pkg::ColorW-1:0] color;
        rle_pkg::record_t           rec;
        color = {px.red[7:3], px.green[7:2], px.blue[7:3]};

        // A colour change only closes a run that holds at least one pixel, so the
        // first pixel after reset or after an image end never emits anything here.
        if (color != pending_color && pending_length != '0)
        begin
            rec.run_length = pending_length;
            rec.run_color  = pending_color;
            rec.image_end  = 1'b0;
            expected_records.push_back(rec);
            pending_length = '0;
        end
        pending_color  = color;
        pending_length = pending_length + {{(rle_pkg::CountW-1){1'b0}}, 1'b1};

        // A full run leaves at once; when that pixel is also final it carries the
        // image end itself and nothing is left to flush.
        if (pending_length == rle_pkg::RunLimit)
        begin
            rec.run_length = pending_length;
            rec.run_color  = pending_color;
            rec.image_end  = px.final_pixel;
            expected_records.push_back(rec);
            pending_length = '0;
        end

        // The final pixel flushes whatever is pending and returns the state to reset.
        if (px.final_pixel)
        begin
            if (pending_length != '0)
            begin
                rec.run_length = pending_length;
                rec.run_color  = pending_color;
                rec.image_end  = 1'b1;
                expected_records.push_back(rec);
            end
            pending_length = '0;
            pending_color  = '0;
        end
    endtask

    // Sends one pixel. The sender may idle first, then holds valid until the transaction
    // is accepted at a rising edge. Valid is left high so that the next call can continue
    // without a gap.
    task automatic send_pixel(input rle_pkg::pixel_t px);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pixels_if.valid <= 1'b0;
            @(negedge clk);
        end
        pixels_if.valid <= 1'b1;
        pixels_if.data  <= px;
        do
            @(posedge clk);
        while (!pixels_if.ready);
        predict_run_records(px);
    endtask

    task automatic send_run(input rle_pkg::pixel_t px, input int length);
        for (int i = 0; i < length; i++)
        begin
            send_pixel(px);
        end
    endtask

    // Lowers valid and waits until every predicted record has been checked, then keeps
    // watching for a settle time in which any record that should not exist would show.
    task automatic drain_records();
        @(negedge clk);
        pixels_if.valid <= 1'b0;
        while (expected_records.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SettleCycles) @(posedge clk);
    endtask

    // Every record transaction is compared field by field with the oldest prediction.
    always @(posedge clk)
    begin
        rle_pkg::record_t want;
        if (rst_n && records_if.valid && records_if.ready)
        begin
            if (expected_records.size() == 0)
            begin
                $error("unexpected record: run_length %0d run_color %h image_end %0d",
                       records_if.data.run_length, records_if.data.run_color,
                       records_if.data.image_end);
                error_count++;
            end
            else
            begin
                want = expected_records.pop_front();
                if (records_if.data.run_length !== want.run_length)
                begin
                    $error("run_length: expected %0d, actual %0d",
                           want.run_length, records_if.data.run_length);
                    error_count++;
                end
                if (records_if.data.run_color !== want.run_color)
                begin
                    $error("run_color: expected %h, actual %h",
                           want.run_color, records_if.data.run_color);
                    error_count++;
                end
                if (records_if.data.image_end !== want.image_end)
                begin
                    $error("image_end: expected %0d, actual %0d",
                           want.image_end, records_if.data.image_end);
                    error_count++;
                end
            end
        end
    end

    // Short hand-picked sequence: channel extremes, colours that differ only in the
    // bits dropped by the 565 reduction, single-pixel images, and a final pixel that
    // both changes colour and flushes.
    task automatic test_directed_pixels();
        // Black as the very first pixel matches the reset colour but opens a run.
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
        // Low bits set everywhere still reduce to black, so the run grows to two.
        send_pixel(make_pixel(8'h07, 8'h03, 8'h07, 1'b0));
        // White closes the black run.
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0));
        // Same 565 white with the low bits clear, final: flush of a two-pixel run.
        send_pixel(make_pixel(8'hF8, 8'hFC, 8'hF8, 1'b1));
        // A one-pixel image right after an image end.
        send_pixel(make_pixel(8'h08, 8'h00, 8'h00, 1'b1));
        // Change and flush on the same final pixel gives two records.
        send_pixel(make_pixel(8'h00, 8'h04, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h08, 1'b1));
        // Pure primaries one after another; each change of colour closes the previous run.
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(8'hFF, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h00, 8'hFF, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'hFF, 1'b0));
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b1));
        // Black after an image end starts a fresh run even though the colour matches.
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 1'b0));
        send_pixel(make_pixel(8'h05, 8'h02, 8'h01, 1'b1));
        // Alternating bit patterns in each channel, then the top bit alone and all other bits.
        send_pixel(make_pixel(8'hAA, 8'h55, 8'hAA, 1'b0));
        send_pixel(make_pixel(8'h55, 8'hAA, 8'h55, 1'b0));
        send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 1'b0));
        send_pixel(make_pixel(8'h7F, 8'h7F, 8'h7F, 1'b1));
        drain_records();
    endtask

    // Runs that reach the 65535-pixel limit: once on a final pixel, once followed by
    // more of the same colour, and once followed by a different colour.
    task automatic test_run_limit();
        // The limit reached on the final pixel: one record with image_end, no flush.
        send_run(make_pixel(8'h80, 8'h80, 8'h80, 1'b0), 65534);
        send_pixel(make_pixel(8'h80, 8'h80, 8'h80, 1'b1));
        drain_records();

        // A full run, then the same colour continues as a new run.
        send_run(make_pixel(8'h10, 8'h10, 8'h10, 1'b0), 65535);
        send_run(make_pixel(8'h17, 8'h13, 8'h17, 1'b0), 2);
        send_pixel(make_pixel(8'hC8, 8'h40, 8'h20, 1'b1));
        drain_records();

        // A full run, then a different colour: the empty run emits nothing on change.
        send_run(make_pixel(8'h00, 8'hFC, 8'h00, 1'b0), 65535);
        send_pixel(make_pixel(8'hF8, 8'h00, 8'hF8, 1'b1));
        drain_records();
    endtask

    // Random images. Most are well-formed: a few runs of jittered colours (the bits
    // dropped by the reduction are random) ending in a final pixel. The rest is noise
    // with random final flags, or runs of jittered colours that never end their image.
    task automatic test_random_images(input int item_count);
        int                sent;
        int                mode;
        int                run_count;
        int                run_len;
        logic [23:0]       base;
        logic [31:0]       noise;
        logic              last;
        rle_pkg::pixel_t   px;
        sent = 0;
        base = 24'($urandom());
        while (sent < item_count)
        begin
            mode = $urandom_range(99);
            if (mode < 85)
            begin
                run_count = $urandom_range(1, 6);
                for (int r = 0; r < run_count; r++)
                begin
                    // Repeating the base colour now and then merges two runs.
                    if ($urandom_range(3) != 0)
                    begin
                        base = 24'($urandom());
                    end
                    run_len = ($urandom_range(9) == 0) ? $urandom_range(9, 30)
                                                       : $urandom_range(1, 6);
                    for (int p = 0; p < run_len; p++)
                    begin
                        // From 70 up the image is left open and runs on into the next.
                        last = (mode < 70) && (r == run_count - 1) && (p == run_len - 1);
                        px = make_pixel({base[23:19], 3'($urandom_range(7))},
                                        {base[15:10], 2'($urandom_range(3))},
                                        {base[7:3],   3'($urandom_range(7))}, last);
                        send_pixel(px);
                        sent++;
                    end
                end
            end
            else
            begin
                run_len = $urandom_range(1, 10);
                for (int p = 0; p < run_len; p++)
                begin
                    noise = $urandom();
                    px = noise[$bits(rle_pkg::pixel_t)-1:0];
                    px.final_pixel = ($urandom_range(7) == 0);
                    send_pixel(px);
                    sent++;
                end
            end
        end
        drain_records();
    endtask

    // Watchdog: a hung handshake or a missing record ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CycleLimit)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        rst_n           = 1'b0;
        pixels_if.valid = 1'b0;
        pixels_if.data  = '0;
        pending_color   = '0;
        pending_length  = '0;
        error_count     = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_pixels();
        test_run_limit();

        // Random images under each mix of sender gaps and receiver stalls.
        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_images(ImageItems);
        send_idle_pct = 49;
        stall_pct     = 0;
        test_random_images(ImageItems);
        send_idle_pct = 0;
        stall_pct     = 49;
        test_random_images(ImageItems);
        send_idle_pct = 26;
        stall_pct     = 26;
        test_random_images(ImageItems);

        if (error_count == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/rle_pkg.sv
rtl/core/rle_stream_if.sv
rtl/core/rle_run_tracker.sv
rtl/core/rle_record_serializer.sv
rtl/core/rgb565_run_length_encoder_unit.sv
tb/tb.sv
